/* hdl/rds_matched_fir_filter_top_defines.svh */
// ----------------------------------------------------------------------------
// RDS matched FIR filter assertion macros
// Shared property forms for the concurrent checks of the filter.
// ----------------------------------------------------------------------------
`ifndef RDS_MATCHED_FIR_FILTER_TOP_DEFINES_SVH
`define RDS_MATCHED_FIR_FILTER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define RDSMF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rdsmf check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define RDSMF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rdsmf check failed");

`endif

/* hdl/rdsmf_pkg.sv */
// ----------------------------------------------------------------------------
// RDS matched FIR filter package
// Widths, coefficient table, control types and states shared by the filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rdsmf_pkg;

	localparam int SampleW   = 16;
	localparam int CoefW     = 16;
	localparam int ProdW     = SampleW + CoefW;
	localparam int AccW      = 40;
	localparam int CoefCount = 83;
	localparam int CoefIdxW  = $clog2(CoefCount);
	localparam int TapIdxW   = 8;
	localparam int TapsDef   = 83;

	typedef logic signed [SampleW-1:0] sample_t;
	typedef logic signed [CoefW-1:0]   coef_t;
	typedef logic signed [ProdW-1:0]   prod_t;
	typedef logic signed [AccW-1:0]    acc_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic clear;
		logic mul_en;
	} mac_ctl_t;

	localparam coef_t CoefTable [CoefCount] = '{
		-16'sd3,   -16'sd4,   -16'sd4,   -16'sd3,   -16'sd2,
		-16'sd1,    16'sd1,    16'sd3,    16'sd5,    16'sd7,
		 16'sd9,    16'sd10,   16'sd11,   16'sd10,   16'sd8,
		 16'sd4,   -16'sd2,   -16'sd10,  -16'sd20,  -16'sd32,
		-16'sd46,  -16'sd62,  -16'sd80,  -16'sd98,  -16'sd117,
		-16'sd136, -16'sd154, -16'sd170, -16'sd184, -16'sd195,
		-16'sd202, -16'sd205, -16'sd203, -16'sd197, -16'sd186,
		-16'sd170, -16'sd150, -16'sd125, -16'sd97,  -16'sd66,
		-16'sd34,   16'sd0,    16'sd34,   16'sd66,   16'sd97,
		 16'sd125,  16'sd150,  16'sd170,  16'sd186,  16'sd197,
		 16'sd203,  16'sd205,  16'sd202,  16'sd195,  16'sd184,
		 16'sd170,  16'sd154,  16'sd136,  16'sd117,  16'sd98,
		 16'sd80,   16'sd62,   16'sd46,   16'sd32,   16'sd20,
		 16'sd10,   16'sd2,   -16'sd4,   -16'sd8,   -16'sd10,
		-16'sd11,  -16'sd10,  -16'sd9,   -16'sd7,   -16'sd5,
		-16'sd3,   -16'sd1,    16'sd1,    16'sd2,    16'sd3,
		 16'sd4,    16'sd4,    16'sd3
	};

	// taps past the table carry a zero coefficient
	function automatic coef_t coef_at(input logic [TapIdxW-1:0] idx);
		coef_t c;
		c = '0;
		if (idx < TapIdxW'(CoefCount)) begin
			c = CoefTable[idx[CoefIdxW-1:0]];
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* hdl/rds_matched_fir_filter_top.sv */
// ----------------------------------------------------------------------------
// RDS matched FIR filter top level
// Matched filter for the baseband RDS bit shape over a TAPS-deep sample line.
// ----------------------------------------------------------------------------
// Each accepted request shifts its sample into a TAPS-entry shift line, which
// then recirculates once past a single 16x16 multiplier so that tap i meets
// coefficient i, newest sample against coefficient 0. A request runs through
// the RUN, DRAIN and DONE states to a result in the output register, set by
// the one shared multiply-accumulate unit; the input stalls until the machine
// is back in IDLE, which DONE leaves only once the output register is free.
// The output register lets the next request start while the previous result
// waits. Results are 40-bit sums scaled by 2^11.
`default_nettype none

`include "rds_matched_fir_filter_top_defines.svh"

module rds_matched_fir_filter_top #(
	parameter int TAPS = rdsmf_pkg::TapsDef
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rdsmf_pkg::sample_t sample_in,
	input  wire logic               sample_valid,
	output logic                    sample_stall,
	output rdsmf_pkg::acc_t         filtered_out,
	output logic                    filtered_valid,
	input  wire logic               filtered_stall
);
	import rdsmf_pkg::*;

	localparam int CntW = $clog2(TAPS);

	state_t         state_q;
	state_t         state_nxt;
	logic [CntW-1:0] cnt_q;
	sample_t        line_q [TAPS];
	mac_ctl_t       mac_ctl;
	acc_t           acc;
	acc_t           out_q;
	logic           out_vld_q;
	logic           in_acc;
	logic           out_free;
	logic           rotate;
	logic           last_tap;

	assign in_acc   = sample_valid && !sample_stall;
	assign out_free = !out_vld_q || !filtered_stall;
	assign last_tap = (cnt_q == CntW'(TAPS - 1));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (last_tap) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		sample_stall   = 1'b1;
		rotate         = 1'b0;
		mac_ctl.clear  = 1'b0;
		mac_ctl.mul_en = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_stall  = 1'b0;
				mac_ctl.clear = sample_valid;
			end
			ST_RUN: begin
				rotate         = 1'b1;
				mac_ctl.mul_en = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (in_acc) begin
				cnt_q <= '0;
			end else if (rotate && !last_tap) begin
				cnt_q <= cnt_q + CntW'(1);
			end
		end
	end

	// shift in on a request, recirculate toward the head while summing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				line_q[k] <= '0;
			end
		end else if (in_acc) begin
			line_q[0] <= sample_in;
			for (int k = 1; k < TAPS; k++) begin
				line_q[k] <= line_q[k-1];
			end
		end else if (rotate) begin
			line_q[TAPS-1] <= line_q[0];
			for (int k = 0; k < TAPS - 1; k++) begin
				line_q[k] <= line_q[k+1];
			end
		end
	end

	rdsmf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.sample (line_q[0]),
		.coef   (coef_at(TapIdxW'(cnt_q))),
		.acc    (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_vld_q <= 1'b1;
		end else if (!filtered_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q <= acc;
		end
	end

	assign filtered_out   = out_q;
	assign filtered_valid = out_vld_q;

	`RDSMF_ASSERT_NEXT(a_accept_starts, in_acc, state_q == ST_RUN && cnt_q == '0)
	`RDSMF_ASSERT_NOW(a_cnt_range, state_q == ST_RUN, cnt_q <= CntW'(TAPS - 1))
	`RDSMF_ASSERT_NEXT(a_done_loads, state_q == ST_DONE && out_free, out_vld_q && state_q == ST_IDLE)
	`RDSMF_ASSERT_NEXT(a_run_ends, state_q == ST_RUN && last_tap, state_q == ST_DRAIN)

endmodule

`default_nettype wire

/* hdl/rdsmf_mac.sv */
// ----------------------------------------------------------------------------
// RDS matched FIR filter multiply-accumulate unit
// One registered sample-by-coefficient product per cycle while mul_en is set,
// summed into a 40-bit wrapping accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module rdsmf_mac (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rdsmf_pkg::mac_ctl_t ctl,
	input  wire rdsmf_pkg::sample_t  sample,
	input  wire rdsmf_pkg::coef_t    coef,
	output rdsmf_pkg::acc_t          acc
);
	import rdsmf_pkg::*;

	prod_t prod_s1;
	logic  prod_vld_s1;
	acc_t  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= ctl.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= ProdW'(sample * coef);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (prod_vld_s1) begin
			acc_q <= acc_q + AccW'(prod_s1);
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire
